/* sv/u8cp_pkg.sv */
// ----------------------------------------------------------------------------
// u8cp_pkg: shared types and constants for the utf-8 to code page transcoder
// Holds the register indexes, mode codes, result word layout and the
// windows-1252 c1 mapping used to fold code points back into single bytes.
// ----------------------------------------------------------------------------
package u8cp_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 1;
	localparam int DATA_W  = 16;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE     = 1'd0;
	localparam logic [IDX_W-1:0] REG_CAPACITY = 1'd1;

	// code page modes (3 behaves as other page)
	localparam logic [MODE_W-1:0] MODE_PASS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_1252  = 2'd1;

	// reset values of the registers
	localparam logic [MODE_W-1:0]  MODE_RESET     = MODE_1252;
	localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'd256;

	// sequence state
	localparam logic [1:0] PEND_NONE   = 2'd0;
	localparam logic [1:0] PEND_LEAD   = 2'd1;
	localparam logic [1:0] PEND_MIDDLE = 2'd2;

	localparam logic [BYTE_W-1:0] QMARK = 8'h3F;

	// one result word
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               is_end;
		logic [COUNT_W-1:0] count;
	} result_t;

	// code points for bytes 0x80..0x9F in windows-1252
	localparam logic [15:0] C1_TABLE [32] = '{
		16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
		16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
	};

	// fold a decoded code point into a code page byte
	function automatic logic [BYTE_W-1:0] map_point(input logic [MODE_W-1:0] mode,
			input logic [15:0] u);
		logic [BYTE_W-1:0] r;
		r = QMARK;
		if (mode == MODE_1252) begin
			if (u[15:8] == 8'h00 && u[7]) begin
				r = u[7:0];
			end else begin
				for (int k = 0; k < 32; k++) begin
					if (C1_TABLE[k] == u) begin
						r = {3'b100, 5'(k)};
					end
				end
			end
		end else if (u[15:8] == 8'h00) begin
			r = u[7:0];
		end
		return r;
	endfunction

endpackage

/* sv/utf8_to_single_byte_codepage.sv */
// ----------------------------------------------------------------------------
// utf8_to_single_byte_codepage: utf-8 to single-byte code page transcoder
// Decodes a nul-terminated utf-8 byte stream into code page bytes and closes
// each string with an end word that carries the emitted byte count.
// ----------------------------------------------------------------------------
// Takes one input byte per cycle while in_stall is low. A byte is captured in
// an input register, decoded from that register and its results (none, one, or
// up to three when a nul cuts off a pending sequence) go into a four-entry
// result queue that drives the output one word per cycle while out_stall is
// low. Sustained rate is one byte per cycle as long as each byte yields at most
// one word and the output is not stalled; the input stalls while the queue
// lacks room for three more words. An accepted byte passes the input register
// and then the result queue before its first result word appears. Registers
// may be written only while the block is idle.
module utf8_to_single_byte_codepage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [u8cp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [u8cp_pkg::DATA_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [u8cp_pkg::BYTE_W-1:0]    in_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [u8cp_pkg::BYTE_W-1:0]    out_byte,
	output logic                           is_end,
	output logic [u8cp_pkg::COUNT_W-1:0]   byte_count
);
	import u8cp_pkg::*;

	localparam int QDEPTH = 4;

	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] capacity_q;
	logic [BYTE_W-1:0]  lead_q, middle_q;
	logic [1:0]         pend_q;
	logic [COUNT_W-1:0] emitted_q;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;

	result_t            queue_q [QDEPTH];
	logic [2:0]         qcnt_q;

	logic               pop, room, process, in_take;
	logic [2:0]         qbase;

	// decode outputs
	logic               req0, req1, req_end;
	logic [BYTE_W-1:0]  val0, val1;
	logic [BYTE_W-1:0]  lead_d, middle_d;
	logic [1:0]         pend_d;
	logic               pass0, pass1;
	logic [COUNT_W-1:0] limit, cnt1, cnt2;
	logic [2:0]         nres;
	result_t            new_res [3];

	// handshake and queue room
	assign out_valid = (qcnt_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign qbase     = qcnt_q - 3'(pop);
	assign room      = (qbase <= 3'd1);
	assign process   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign in_take   = in_valid && !in_stall;

	assign out_byte   = queue_q[0].data;
	assign is_end     = queue_q[0].is_end;
	assign byte_count = queue_q[0].count;

	// decode of the held byte against the sequence state
	always_comb begin
		req0     = 1'b0;
		req1     = 1'b0;
		req_end  = 1'b0;
		val0     = QMARK;
		val1     = QMARK;
		lead_d   = lead_q;
		middle_d = middle_q;
		pend_d   = pend_q;
		if (mode_q == MODE_PASS) begin
			pend_d = PEND_NONE;
			if (byte_s1 == 8'h00) begin
				req_end = 1'b1;
			end else begin
				req0 = 1'b1;
				val0 = byte_s1;
			end
		end else begin
			case (pend_q)
				PEND_LEAD: begin
					if (byte_s1 == 8'h00) begin
						req0    = 1'b1;
						req_end = 1'b1;
					end else if (lead_q[7:5] == 3'b110) begin
						req0   = 1'b1;
						val0   = map_point(mode_q, {5'b0, lead_q[4:0], byte_s1[5:0]});
						pend_d = PEND_NONE;
					end else begin
						middle_d = byte_s1;
						pend_d   = PEND_MIDDLE;
					end
				end
				PEND_MIDDLE: begin
					if (byte_s1 == 8'h00) begin
						req0    = 1'b1;
						req1    = 1'b1;
						val1    = middle_q[7] ? QMARK : middle_q;
						req_end = 1'b1;
					end else begin
						req0   = 1'b1;
						val0   = map_point(mode_q,
							{lead_q[3:0], middle_q[5:0], byte_s1[5:0]});
						pend_d = PEND_NONE;
					end
				end
				default: begin
					pend_d = PEND_NONE;
					if (byte_s1 == 8'h00) begin
						req_end = 1'b1;
					end else if (!byte_s1[7]) begin
						req0 = 1'b1;
						val0 = byte_s1;
					end else if (byte_s1[7:5] == 3'b110 || byte_s1[7:4] == 4'b1110) begin
						lead_d = byte_s1;
						pend_d = PEND_LEAD;
					end else begin
						req0 = 1'b1;
					end
				end
			endcase
		end
		if (req_end) begin
			pend_d = PEND_NONE;
		end
	end

	// capacity gating, later bytes past the limit are dropped
	always_comb begin
		limit = (capacity_q == '0) ? '0 : capacity_q - 16'd1;
		pass0 = req0 && (emitted_q < limit);
		cnt1  = emitted_q + COUNT_W'(pass0);
		pass1 = req1 && (cnt1 < limit);
		cnt2  = cnt1 + COUNT_W'(pass1);
		nres  = 3'(pass0) + 3'(pass1) + 3'(req_end);
		if (pass0) begin
			new_res[0] = '{data: val0, is_end: 1'b0, count: '0};
		end else begin
			new_res[0] = '{data: '0, is_end: 1'b1, count: cnt2};
		end
		if (pass1) begin
			new_res[1] = '{data: val1, is_end: 1'b0, count: '0};
		end else begin
			new_res[1] = '{data: '0, is_end: 1'b1, count: cnt2};
		end
		new_res[2] = '{data: '0, is_end: 1'b1, count: cnt2};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				REG_CAPACITY: capacity_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			middle_q  <= '0;
			pend_q    <= PEND_NONE;
			emitted_q <= '0;
		end else if (process) begin
			lead_q    <= lead_d;
			middle_q  <= middle_d;
			pend_q    <= pend_d;
			emitted_q <= req_end ? '0 : cnt2;
		end
	end

	// result queue count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= qbase + (process ? nres : 3'd0);
		end
	end

	// result queue words, head at entry zero
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (process && 3'(i) >= qbase && (3'(i) - qbase) < nres) begin
				queue_q[i] <= new_res[2'(3'(i) - qbase)];
			end else if (pop && i < QDEPTH - 1) begin
				queue_q[i] <= queue_q[(i + 1) % QDEPTH];
			end
		end
	end

endmodule

/* sv/u8cp_checker.sv */
// ----------------------------------------------------------------------------
// u8cp_port_checks: port level checks for the code page transcoder
// Watches the result channel for handshake holding and word layout.
// ----------------------------------------------------------------------------
module u8cp_port_checks (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [u8cp_pkg::BYTE_W-1:0]    out_byte,
	input  logic                           is_end,
	input  logic [u8cp_pkg::COUNT_W-1:0]   byte_count
);
	import u8cp_pkg::*;

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(is_end) && $stable(byte_count))
		else $error("result word changed while stalled");

	// byte words carry no count
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> byte_count == '0)
		else $error("byte word with nonzero count");

	// end words carry a zero byte and a count below the full range
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> out_byte == '0 && byte_count != 16'hFFFF)
		else $error("malformed end word");

endmodule

bind utf8_to_single_byte_codepage u8cp_port_checks u_u8cp_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.is_end     (is_end),
	.byte_count (byte_count)
);
